// ===== rtl/core/tcgr_pkg.sv =====
`timescale 1ns / 1ps

package tcgr_pkg;

  // font geometry
  localparam int GlyphDim   = 8;
  localparam int FontGlyphs = 256;
  localparam int FontRows   = FontGlyphs * GlyphDim;
  localparam int GlyphW     = $clog2(FontGlyphs);
  localparam int FontAddrW  = $clog2(FontRows);
  localparam int EraseGlyph = 128;

  // configuration
  localparam int           WidthW     = 14;
  localparam logic [13:0]  WidthReset = 14'd1024;

  // command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // control characters
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharReturn  = 8'h0D;
  localparam logic [7:0] CharTab     = 8'h09;

  // input operation codes
  typedef enum logic [2:0] {
    OpPutChar   = 3'd0,
    OpBackspace = 3'd1,
    OpLoadFont  = 3'd2,
    OpSetCol    = 3'd3,
    OpSetRow    = 3'd4
  } opcode_e;

  // work kinds handed to the back end
  typedef enum logic [1:0] {
    CmdStatus = 2'd0,
    CmdDraw   = 2'd1,
    CmdFont   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [2:0]  glyph_row;
    logic [7:0]  row_bits;
    logic [31:0] color;
    logic [15:0] new_position;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] pixel_index;
    logic [31:0] pixel_color;
    logic [15:0] cursor_col;
    logic [15:0] cursor_line;
    logic        last;
  } result_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [GlyphW-1:0]  glyph;
    logic [2:0]         glyph_row;
    logic [7:0]         row_bits;
    logic [31:0]        color;
    logic [31:0]        base;
    logic [15:0]        cursor_col;
    logic [15:0]        cursor_line;
  } cmd_t;

  // queue handshake toward the producer
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } queue_wr_t;

endpackage

// ===== rtl/core/tcgr_queue.sv =====
`timescale 1ns / 1ps

module tcgr_queue import tcgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  queue_wr_t wr_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  logic      pop_i
);

  cmd_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i.push && !full_o) begin
      entry_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i.push && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QueueCntW'(wr_i.push && !full_o) - QueueCntW'(pop_i && valid_o);
    end
  end

endmodule

// ===== rtl/core/tcgr_front.sv =====
`timescale 1ns / 1ps

module tcgr_front import tcgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             in_data_i,
  input  logic [WidthW-1:0] screen_width_i,
  output queue_wr_t         wr_o,
  input  logic              full_i
);

  typedef enum logic [3:0] {
    FIdle = 4'b0001,
    FCalc = 4'b0010,
    FMul  = 4'b0100,
    FPush = 4'b1000
  } front_state_e;

  front_state_e      state_q, state_d;
  item_t             item_q;
  logic [15:0]       col_q, row_q;
  logic [15:0]       draw_col_q, draw_row_q;
  cmd_kind_e         kind_q;
  logic [GlyphW-1:0] glyph_q;
  logic [31:0]       base_q;

  logic [15:0]       cols;
  logic [15:0]       col_n, row_n, draw_col_n, draw_row_n;
  cmd_kind_e         kind_n;
  logic [GlyphW-1:0] glyph_n;
  logic              do_check;
  logic              glyph_ok;
  logic [32:0]       row_prod;

  assign cols     = {5'b0, screen_width_i[WidthW-1:3]};
  assign glyph_ok = ({1'b0, item_q.char_code} < 9'(FontGlyphs));

  // classify the item and work out the new cursor
  always_comb begin
    col_n      = col_q;
    row_n      = row_q;
    draw_col_n = col_q;
    draw_row_n = row_q;
    kind_n     = CmdStatus;
    glyph_n    = item_q.char_code[GlyphW-1:0];
    do_check   = 1'b0;
    unique case (item_q.opcode)
      OpPutChar: begin
        do_check = 1'b1;
        if (item_q.char_code == CharNewline) begin
          col_n = '0;
          row_n = row_q + 16'd1;
        end else if (item_q.char_code == CharReturn) begin
          col_n = '0;
        end else if (item_q.char_code == CharTab) begin
          col_n = {col_q[15:3], 3'b000} + 16'd8;
        end else begin
          col_n = col_q + 16'd1;
          if (glyph_ok) begin
            kind_n = CmdDraw;
          end
        end
        if (do_check && (col_n >= cols)) begin
          col_n = '0;
          row_n = row_n + 16'd1;
        end
      end
      OpBackspace: begin
        if (col_q != '0) begin
          col_n      = col_q - 16'd1;
          draw_col_n = col_q - 16'd1;
          kind_n     = CmdDraw;
          glyph_n    = GlyphW'(EraseGlyph);
        end
      end
      OpLoadFont: begin
        if (glyph_ok) begin
          kind_n = CmdFont;
        end
      end
      OpSetCol: col_n = item_q.new_position;
      OpSetRow: row_n = item_q.new_position;
      default: ;
    endcase
  end

  // glyph origin: 8*row*width + 8*col, modulo 2^32
  assign row_prod = 33'({draw_row_q, 3'b000}) * 33'(screen_width_i);

  // sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIdle: if (in_valid_i) state_d = FCalc;
      FCalc: state_d = FMul;
      FMul:  state_d = FPush;
      FPush: if (!full_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FCalc) begin
        col_q <= col_n;
        row_q <= row_n;
      end
    end
  end

  // item and command payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (state_q == FCalc) begin
      draw_col_q <= draw_col_n;
      draw_row_q <= draw_row_n;
      kind_q     <= kind_n;
      glyph_q    <= glyph_n;
    end
    if (state_q == FMul) begin
      base_q <= row_prod[31:0] + {13'b0, draw_col_q, 3'b000};
    end
  end

  assign in_ready_o = (state_q == FIdle);

  assign wr_o.push            = (state_q == FPush) && !full_i;
  assign wr_o.cmd.kind        = kind_q;
  assign wr_o.cmd.glyph       = glyph_q;
  assign wr_o.cmd.glyph_row   = item_q.glyph_row;
  assign wr_o.cmd.row_bits    = item_q.row_bits;
  assign wr_o.cmd.color       = item_q.color;
  assign wr_o.cmd.base        = base_q;
  assign wr_o.cmd.cursor_col  = col_q;
  assign wr_o.cmd.cursor_line = row_q;

endmodule

// ===== rtl/core/tcgr_back.sv =====
`timescale 1ns / 1ps

module tcgr_back import tcgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic [WidthW-1:0] screen_width_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_data_o
);

  typedef enum logic [3:0] {
    BIdle = 4'b0001,
    BLoad = 4'b0010,
    BEmit = 4'b0100,
    BStat = 4'b1000
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [63:0]       mask_q, mask_d;
  logic [2:0]        iy_q, iy_d;
  logic [31:0]       row_base_q, row_base_d;
  logic [31:0]       color_q;
  logic [15:0]       ccol_q, cline_q;
  logic [GlyphW-1:0] glyph_q;
  logic [7:0]        rd_data_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [7:0]        font_mem [FontRows];
  logic [FontAddrW-1:0] rd_addr, wr_addr;
  logic              mem_we;
  logic              latch_cmd;

  logic              slot_free;
  logic [7:0]        cur_row;
  logic [2:0]        ix;
  logic [63:0]       mask_clr;
  logic [2:0]        load_row;
  logic              emit;
  result_t           res;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cur_row   = mask_q[{iy_q, 3'b000} +: 8];
  assign mask_clr  = mask_q & ~(64'd1 << {iy_q, ix});
  assign load_row  = cnt_q[2:0] - 3'd1;
  assign rd_addr   = {glyph_q, cnt_q[2:0]};
  assign wr_addr   = {cmd_i.glyph, cmd_i.glyph_row};

  // lowest set bit of the current glyph row
  always_comb begin
    ix = '0;
    for (int i = 7; i >= 0; i--) begin
      if (cur_row[i]) ix = 3'(i);
    end
  end

  // font store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[wr_addr] <= cmd_i.row_bits;
    end
    rd_data_q <= font_mem[rd_addr];
  end

  // command execution
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    iy_d        = iy_q;
    row_base_d  = row_base_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    latch_cmd   = 1'b0;
    emit        = 1'b0;
    res.write_valid = 1'b0;
    res.pixel_index = '0;
    res.pixel_color = '0;
    res.cursor_col  = ccol_q;
    res.cursor_line = cline_q;
    res.last        = 1'b1;
    unique case (state_q)
      BIdle: begin
        res.cursor_col  = cmd_i.cursor_col;
        res.cursor_line = cmd_i.cursor_line;
        if (cmd_valid_i) begin
          if (cmd_i.kind == CmdDraw) begin
            pop_o      = 1'b1;
            latch_cmd  = 1'b1;
            cnt_d      = '0;
            iy_d       = '0;
            row_base_d = cmd_i.base;
            state_d    = BLoad;
          end else if (slot_free) begin
            pop_o  = 1'b1;
            mem_we = (cmd_i.kind == CmdFont);
            emit   = 1'b1;
          end
        end
      end
      BLoad: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != '0) begin
          mask_d[{load_row, 3'b000} +: 8] = rd_data_q;
        end
        if (cnt_q == 4'd8) begin
          state_d = (mask_d == '0) ? BStat : BEmit;
        end
      end
      BEmit: begin
        if (cur_row == '0) begin
          iy_d       = iy_q + 3'd1;
          row_base_d = row_base_q + {18'b0, screen_width_i};
        end else if (slot_free) begin
          emit            = 1'b1;
          res.write_valid = 1'b1;
          res.pixel_index = row_base_q + {29'b0, ix};
          res.pixel_color = color_q;
          res.last        = (mask_clr == '0);
          mask_d          = mask_clr;
          if (mask_clr == '0) state_d = BIdle;
        end
      end
      BStat: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = BIdle;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q     <= mask_d;
    iy_q       <= iy_d;
    row_base_q <= row_base_d;
    out_q      <= out_d;
    if (latch_cmd) begin
      color_q <= cmd_i.color;
      ccol_q  <= cmd_i.cursor_col;
      cline_q <= cmd_i.cursor_line;
      glyph_q <= cmd_i.glyph;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/text_console_glyph_renderer.sv =====
`timescale 1ns / 1ps

// Text console renderer with an 8x8 font held in an internal 2048 x 8 store, which must be
// loaded row by row (load font row) before any glyph is printed. Each input item gives one or
// more results: one pixel write per set glyph bit, top row first and bit 0 first within a row,
// or a single status result when nothing is drawn; every result carries the cursor after the
// item and the final one has last set. The front end takes one item at a time through calc,
// multiply and push states into a 2-entry command queue; the push waits while it is full. The
// back end sets the drawing rate: a drawn glyph loads its eight font rows, then gives its pixel
// writes, holding while the output register is full. Pixel index is x + y * screen_width
// modulo 2^32. screen_width must be written only while idle; the block does not enforce it.
module text_console_glyph_renderer import tcgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WidthW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_data_o
);

  logic [WidthW-1:0] screen_width_q;
  queue_wr_t         qwr;
  logic              q_full, q_valid, q_pop;
  cmd_t              q_cmd;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q <= WidthReset;
    end else if (cfg_valid_i) begin
      screen_width_q <= cfg_data_i;
    end
  end

  // item classification and cursor
  tcgr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .screen_width_i (screen_width_q),
    .wr_o           (qwr),
    .full_i         (q_full)
  );

  // command queue
  tcgr_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (qwr),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // font store and pixel generation
  tcgr_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .pop_o          (q_pop),
    .screen_width_i (screen_width_q),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  // status results are single, final and carry no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_valid |->
      out_data_o.last && out_data_o.pixel_index == '0 && out_data_o.pixel_color == '0)
    else $error("status result with pixel data or without last");

  // the front end never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qwr.push |-> !q_full)
    else $error("push into full command queue");

  // an accepted item keeps the front end busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front end took a second item back to back");

  // the back end only takes commands that are there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcgr_pkg::*;

  // opcodes past the defined set, ignored by the block
  localparam logic [2:0]  OpUndefFirst = 3'd5;
  localparam logic [2:0]  OpUndefLast  = 3'd7;
  // screen widths used by the directed part and the phases
  localparam logic [13:0] WidthLow     = 14'd8;
  localparam logic [13:0] WidthHigh    = 14'd8192;
  localparam logic [13:0] WidthNarrow  = 14'd3;
  // glyphs loaded before anything is printed
  localparam logic [7:0]  GlyphFull    = 8'h00;
  localparam logic [7:0]  GlyphBlank   = 8'h20;
  localparam logic [7:0]  GlyphA       = 8'h41;
  localparam logic [7:0]  GlyphTop     = 8'hFF;

  // one row of the directed plan
  typedef struct packed {
    logic        is_cfg;
    logic [13:0] width;
    item_t       it;
    logic        typed;
    logic [15:0] want_col;
    logic [15:0] want_line;
  } step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [WidthW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  item_t             in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  result_t           out_data_o;

  // shadow of the block state
  logic [7:0]  font_rows [FontRows];
  logic [7:0]  row_loaded [FontGlyphs];
  logic [15:0] cur_col;
  logic [15:0] cur_line;
  logic [13:0] scr_width;
  logic [7:0]  drawable [$];

  result_t item_px [$];
  result_t due_px [$];
  result_t head;
  step_t   plan [$];

  logic        calm = 1'b0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;

  text_console_glyph_renderer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  // item with random content, relevant fields forced
  function automatic item_t cmd(logic [2:0] op, logic [7:0] code, logic [15:0] pos);
    item_t t;
    t.opcode       = op;
    t.char_code    = 8'($urandom);
    t.glyph_row    = 3'($urandom);
    t.row_bits     = 8'($urandom);
    t.color        = $urandom;
    t.new_position = 16'($urandom);
    if (op == OpPutChar || op == OpLoadFont) t.char_code = code;
    if (op == OpSetCol || op == OpSetRow) t.new_position = pos;
    return t;
  endfunction

  function automatic step_t plan_known(logic [2:0] op, logic [7:0] code, logic [15:0] pos,
                                       logic [15:0] col, logic [15:0] ln);
    return '{1'b0, 14'd0, cmd(op, code, pos), 1'b1, col, ln};
  endfunction

  function automatic step_t plan_check(logic [2:0] op, logic [7:0] code, logic [15:0] pos);
    return '{1'b0, 14'd0, cmd(op, code, pos), 1'b0, 16'd0, 16'd0};
  endfunction

  function automatic step_t plan_width(logic [13:0] w);
    return '{1'b1, w, item_t'('0), 1'b0, 16'd0, 16'd0};
  endfunction

  // pixel writes of one glyph at a cell
  task automatic paint(int unsigned glyph, int unsigned col, int unsigned row,
                       logic [31:0] color);
    int unsigned x;
    int unsigned y;
    logic [7:0]  bits;
    result_t     px;
    if (glyph >= FontGlyphs) return;
    for (int iy = 0; iy < GlyphDim; iy++) begin
      bits = font_rows[glyph * GlyphDim + iy];
      for (int ix = 0; ix < GlyphDim; ix++) begin
        if (bits[ix]) begin
          x = ix + col * GlyphDim;
          y = iy + row * GlyphDim;
          px = '0;
          px.write_valid = 1'b1;
          px.pixel_index = x + y * scr_width;
          px.pixel_color = color;
          item_px.push_back(px);
        end
      end
    end
  endtask

  // results of one item, and the state update it causes
  task automatic render_item(item_t it);
    int unsigned c;
    int unsigned r;
    item_px.delete();
    case (it.opcode)
      OpPutChar: begin
        c = cur_col;
        r = cur_line;
        if (it.char_code == CharNewline) begin
          c = 0;
          r = r + 1;
        end else if (it.char_code == CharReturn) begin
          c = 0;
        end else if (it.char_code == CharTab) begin
          c = c - c % GlyphDim + GlyphDim;
        end else begin
          paint(it.char_code, cur_col, cur_line, it.color);
          c = c + 1;
        end
        c = c & 32'h0000_FFFF;
        if (c >= scr_width / GlyphDim) begin
          c = 0;
          r = r + 1;
        end
        cur_col  = c[15:0];
        cur_line = r[15:0];
      end
      OpBackspace: begin
        if (cur_col != 16'd0) begin
          paint(EraseGlyph, cur_col - 16'd1, cur_line, it.color);
          cur_col = cur_col - 16'd1;
        end
      end
      OpLoadFont: begin
        if (it.char_code < FontGlyphs) begin
          font_rows[it.char_code * GlyphDim + it.glyph_row] = it.row_bits;
          if (row_loaded[it.char_code] != 8'hFF) begin
            row_loaded[it.char_code][it.glyph_row] = 1'b1;
            if (row_loaded[it.char_code] == 8'hFF) drawable.push_back(it.char_code);
          end
        end
      end
      OpSetCol: cur_col = it.new_position;
      OpSetRow: cur_line = it.new_position;
      default: ;
    endcase
    if (item_px.size() == 0) item_px.push_back('0);
    foreach (item_px[k]) begin
      item_px[k].cursor_col  = cur_col;
      item_px[k].cursor_line = cur_line;
      item_px[k].last        = (k == item_px.size() - 1);
    end
  endtask

  // one item transfer; typed rows expect a single status result
  task automatic send_item(item_t it, logic typed, logic [15:0] col, logic [15:0] ln);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    render_item(it);
    if (typed) due_px.push_back('{1'b0, 32'd0, 32'd0, col, ln, 1'b1});
    else foreach (item_px[k]) due_px.push_back(item_px[k]);
  endtask

  // width write once every result is out
  task automatic write_width(logic [13:0] w);
    in_valid_i <= 1'b0;
    while (due_px.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scr_width = w;
    n_cfg++;
  endtask

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40) $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // result side pacing
  initial begin : sink_pace
    int unsigned n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = idle_len();
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (due_px.size() == 0) begin
        errors++;
        if (errors <= 40) $display("%0t: result with nothing expected: %h", $time, out_data_o);
      end else begin
        head = due_px.pop_front();
        cmp_field("write_valid", head.write_valid, out_data_o.write_valid);
        cmp_field("pixel_index", head.pixel_index, out_data_o.pixel_index);
        cmp_field("pixel_color", head.pixel_color, out_data_o.pixel_color);
        cmp_field("cursor_col", head.cursor_col, out_data_o.cursor_col);
        cmp_field("cursor_line", head.cursor_line, out_data_o.cursor_line);
        cmp_field("last", head.last, out_data_o.last);
      end
    end
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("FAIL text_console_glyph_renderer");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  seed_glyphs [5];
    item_t       it;
    logic [7:0]  g;
    logic [13:0] w;
    int unsigned sel;
    int unsigned n;

    seed_glyphs = '{GlyphFull, GlyphBlank, GlyphA, 8'(EraseGlyph), GlyphTop};
    foreach (row_loaded[k]) row_loaded[k] = 8'h00;
    cur_col   = 16'd0;
    cur_line  = 16'd0;
    scr_width = WidthReset;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // font for the directed part: one full, one blank, three random glyphs
    foreach (seed_glyphs[k]) begin
      for (int r = 0; r < GlyphDim; r++) begin
        it = cmd(OpLoadFont, seed_glyphs[k], 16'd0);
        it.glyph_row = 3'(r);
        if (seed_glyphs[k] == GlyphFull) it.row_bits = 8'hFF;
        else if (seed_glyphs[k] == GlyphBlank) it.row_bits = 8'h00;
        send_item(it, 1'b0, 16'd0, 16'd0);
      end
    end

    // directed plan
    plan.push_back(plan_known(OpBackspace, 8'd0, 16'd0, 16'd0, 16'd0));
    plan.push_back(plan_known(OpUndefLast, 8'd0, 16'd0, 16'd0, 16'd0));
    plan.push_back(plan_known(OpUndefFirst, 8'd0, 16'd0, 16'd0, 16'd0));
    plan.push_back(plan_known(OpSetRow, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF));
    plan.push_back(plan_known(OpSetCol, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // tab from the last column wraps the column to zero
    plan.push_back(plan_known(OpPutChar, CharTab, 16'd0, 16'd0, 16'hFFFF));
    // newline on the last row wraps the row
    plan.push_back(plan_known(OpPutChar, CharNewline, 16'd0, 16'd0, 16'd0));
    plan.push_back(plan_known(OpSetCol, 8'd0, 16'd5, 16'd5, 16'd0));
    plan.push_back(plan_known(OpPutChar, CharReturn, 16'd0, 16'd0, 16'd0));
    plan.push_back(plan_known(OpSetCol, 8'd0, 16'd3, 16'd3, 16'd0));
    plan.push_back(plan_known(OpPutChar, CharTab, 16'd0, 16'd8, 16'd0));
    plan.push_back(plan_check(OpPutChar, GlyphFull, 16'd0));
    plan.push_back(plan_check(OpPutChar, GlyphBlank, 16'd0));
    plan.push_back(plan_check(OpBackspace, 8'd0, 16'd0));
    plan.push_back(plan_known(OpSetCol, 8'd0, 16'd127, 16'd127, 16'd0));
    // last column of a 1024 wide screen
    plan.push_back(plan_check(OpPutChar, GlyphA, 16'd0));
    plan.push_back(plan_width(WidthHigh));
    plan.push_back(plan_known(OpSetRow, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF));
    plan.push_back(plan_known(OpSetCol, 8'd0, 16'hFFFE, 16'hFFFE, 16'hFFFF));
    // far corner: pixel index wraps at 32 bits
    plan.push_back(plan_check(OpBackspace, 8'd0, 16'd0));
    plan.push_back(plan_check(OpPutChar, GlyphTop, 16'd0));
    // width below one glyph: every put char wraps
    plan.push_back(plan_width(WidthNarrow));
    plan.push_back(plan_check(OpPutChar, CharNewline, 16'd0));
    plan.push_back(plan_check(OpPutChar, GlyphFull, 16'd0));
    plan.push_back(plan_width('1));
    plan.push_back(plan_check(OpUndefFirst, 8'd0, 16'd0));
    plan.push_back(plan_check(OpPutChar, GlyphTop, 16'd0));

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_width(plan[k].width);
      else send_item(plan[k].it, plan[k].typed, plan[k].want_col, plan[k].want_line);
    end

    // random phases, each under its own width
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 1) w = WidthLow;
      else if (ph == 2) w = WidthHigh;
      else if (ph == 3) w = 14'($urandom_range(0, WidthLow - 1));
      else if (ph == 4) w = '1;
      else w = 14'($urandom_range(WidthLow, WidthHigh));
      write_width(w);
      calm = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < 40) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          // whole glyph loaded row by row
          g = 8'($urandom);
          for (int r = 0; r < GlyphDim; r++) begin
            it = cmd(OpLoadFont, g, 16'd0);
            it.glyph_row = 3'(r);
            if ($urandom_range(0, 1) == 0) it.row_bits = 8'($urandom & $urandom);
            send_item(it, 1'b0, 16'd0, 16'd0);
          end
          n += GlyphDim;
        end else begin
          if (sel < 50) begin
            if ($urandom_range(0, 99) < 15) begin
              case ($urandom_range(0, 2))
                0: g = CharNewline;
                1: g = CharReturn;
                default: g = CharTab;
              endcase
            end else begin
              g = drawable[$urandom_range(0, drawable.size() - 1)];
            end
            it = cmd(OpPutChar, g, 16'd0);
          end else if (sel < 62) begin
            it = cmd(OpBackspace, 8'd0, 16'd0);
          end else if (sel < 72) begin
            if ($urandom_range(0, 3) == 0) it = cmd(OpSetCol, 8'd0, 16'($urandom));
            else it = cmd(OpSetCol, 8'd0, 16'($urandom_range(0, scr_width / GlyphDim + 2)));
          end else if (sel < 80) begin
            case ($urandom_range(0, 3))
              0: it = cmd(OpSetRow, 8'd0, 16'($urandom));
              1: it = cmd(OpSetRow, 8'd0, 16'($urandom_range(16'hFFF0, 16'hFFFF)));
              default: it = cmd(OpSetRow, 8'd0, 16'($urandom_range(0, 40)));
            endcase
          end else if (sel < 92) begin
            it = cmd(OpLoadFont, 8'($urandom), 16'd0);
          end else begin
            it = cmd(3'($urandom_range(OpUndefFirst, OpUndefLast)), 8'd0, 16'd0);
          end
          send_item(it, 1'b0, 16'd0, 16'd0);
          n++;
        end
      end
    end
    calm = 1'b0;

    // drain
    in_valid_i <= 1'b0;
    while (due_px.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d items and %0d results across %0d screen widths, %0d glyphs drawable",
             n_items, n_results, n_cfg, drawable.size());
    if (errors == 0) $display("PASS text_console_glyph_renderer");
    else $display("FAIL text_console_glyph_renderer");
    $finish;
  end

endmodule

// ===== text_console_glyph_renderer.f =====
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_queue.sv
rtl/core/tcgr_front.sv
rtl/core/tcgr_back.sv
rtl/core/text_console_glyph_renderer.sv
test/tb_top.sv
